### rtl/bsca_pkg.sv
// Shared types and constants for the bitmap sector chain allocator.
// No dependencies; imported by every module of the block but bsca_ram.
package bsca_pkg;

  localparam int SECTOR_COUNT = 4096;
  localparam int MAX_RUN      = 64;
  localparam int WORD_W       = 64;
  localparam int BIT_W        = 6;
  localparam int MAP_WORDS    = (SECTOR_COUNT + WORD_W - 1) / WORD_W;
  localparam int WADDR_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W        = WADDR_W + BIT_W;
  localparam int RUN_W        = $clog2(MAX_RUN + 1);
  localparam int FC_W         = $clog2(SECTOR_COUNT + 1);
  localparam int SIZE_W       = 8;
  localparam int BASE_W       = 20;
  localparam int SECTOR_W     = 21;
  localparam int STATUS_W     = 2;
  localparam int TAIL_BITS    = SECTOR_COUNT % WORD_W;

  localparam logic [BASE_W-1:0]  BASE_RESET = BASE_W'(73);
  localparam logic [FC_W-1:0]    FC_RESET   = FC_W'(SECTOR_COUNT);
  localparam logic [WADDR_W-1:0] LAST_WORD  = WADDR_W'(MAP_WORDS - 1);
  // bits past the end of the map in a partial last word are held as used
  localparam logic [WORD_W-1:0]  PAD_MASK   =
      (TAIL_BITS == 0) ? '0 : ~((64'd1 << TAIL_BITS) - 64'd1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_SIZE = 2'd2
  } status_t;

  typedef struct packed {
    logic             bad;
    logic [RUN_W-1:0] size;
  } req_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_LOAD,
    B_SCAN,
    B_FLUSH,
    B_ERR
  } back_state_t;

endpackage

### rtl/bsca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bsca_front.sv
// Front end: accepts requests, flags bad sizes, and holds them in a
// two-entry queue for the back end. Depends on bsca_pkg.
module bsca_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [bsca_pkg::SIZE_W-1:0] request_size,
  output logic                        q_valid,
  input  logic                        q_take,
  output bsca_pkg::req_t              q_req
);
  import bsca_pkg::*;

  req_t       ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  req_t       cls;

  always_comb begin
    cls.bad  = (request_size == '0) || (request_size > SIZE_W'(MAX_RUN));
    cls.size = RUN_W'(request_size);
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_req   = ent[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr_ptr] <= cls;
    end
  end

endmodule

### rtl/bsca_back.sv
// Back end: checks free space, scans the free map word by word, marks
// sectors used and emits chain results through an output register.
// Depends on bsca_pkg and bsca_ram.
module bsca_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bsca_pkg::BASE_W-1:0]   base_sector,
  input  logic                          q_valid,
  output logic                          q_take,
  input  bsca_pkg::req_t                q_req,
  output logic                          empty,
  input  logic                          pop,
  output logic [bsca_pkg::SECTOR_W-1:0] sector_number,
  output logic [bsca_pkg::SECTOR_W-1:0] next_sector,
  output logic                          last_of_run,
  output logic [bsca_pkg::STATUS_W-1:0] status
);
  import bsca_pkg::*;

  back_state_t          state, state_next;
  logic [BASE_W-1:0]    base;
  logic [FC_W-1:0]      free_count;
  logic [MAP_WORDS-1:0] valid;
  logic [WADDR_W-1:0]   addr;
  logic [WORD_W-1:0]    word;
  logic [WORD_W-1:0]    rdata;
  logic [RUN_W-1:0]     remaining;
  logic [SECTOR_W-1:0]  pend;
  logic                 pend_v;
  status_t              err_code;
  logic                 out_valid;

  logic                 load_ok;
  logic                 start;
  logic                 reject;
  status_t              reject_code;
  logic                 ram_re;
  logic                 ram_we;
  logic                 load_word;
  logic                 alloc;
  logic                 addr_inc;
  logic                 emit;
  logic [SECTOR_W-1:0]  emit_sec;
  logic [SECTOR_W-1:0]  emit_next;
  logic                 emit_last;
  status_t              emit_status;
  logic [WORD_W-1:0]    free_bits;
  logic [BIT_W-1:0]     low_bit;
  logic [SECTOR_W-1:0]  found_sec;

  bsca_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (word),
    .re    (ram_re),
    .raddr (addr),
    .rdata (rdata)
  );

  assign load_ok   = !out_valid || pop;
  assign free_bits = ~word;
  assign found_sec = SECTOR_W'(base) + SECTOR_W'({addr, low_bit});

  // lowest free bit of the working word
  always_comb begin
    low_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        low_bit = BIT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    q_take      = 1'b0;
    start       = 1'b0;
    reject      = 1'b0;
    reject_code = ST_BAD_SIZE;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    load_word   = 1'b0;
    alloc       = 1'b0;
    addr_inc    = 1'b0;
    emit        = 1'b0;
    emit_sec    = '0;
    emit_next   = '0;
    emit_last   = 1'b0;
    emit_status = ST_OK;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          if (q_req.bad) begin
            reject     = 1'b1;
            state_next = B_ERR;
          end else if (free_count < FC_W'(q_req.size)) begin
            reject      = 1'b1;
            reject_code = ST_NO_SPACE;
            state_next  = B_ERR;
          end else begin
            start      = 1'b1;
            state_next = B_READ;
          end
        end
      end
      B_READ: begin
        ram_re     = 1'b1;
        state_next = B_LOAD;
      end
      B_LOAD: begin
        load_word  = 1'b1;
        state_next = B_SCAN;
      end
      B_SCAN: begin
        if (remaining == '0) begin
          ram_we     = 1'b1;
          state_next = B_FLUSH;
        end else if (free_bits == '0) begin
          ram_we     = 1'b1;
          addr_inc   = 1'b1;
          state_next = B_READ;
        end else if (!pend_v || load_ok) begin
          alloc     = 1'b1;
          emit      = pend_v;
          emit_sec  = pend;
          emit_next = found_sec;
        end
      end
      B_FLUSH: begin
        if (load_ok) begin
          emit       = 1'b1;
          emit_sec   = pend;
          emit_last  = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_ERR: begin
        if (load_ok) begin
          emit        = 1'b1;
          emit_last   = 1'b1;
          emit_status = err_code;
          state_next  = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= BASE_RESET;
      free_count <= FC_RESET;
      valid      <= '0;
      pend_v     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        base <= base_sector;
      end
      if (start) begin
        free_count <= free_count - FC_W'(q_req.size);
        pend_v     <= 1'b0;
      end else if (alloc) begin
        pend_v <= 1'b1;
      end
      if (ram_we) begin
        valid[addr] <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      addr      <= '0;
      remaining <= q_req.size;
    end else begin
      if (addr_inc) begin
        addr <= addr + WADDR_W'(1);
      end
      if (alloc) begin
        remaining <= remaining - RUN_W'(1);
      end
    end
    if (reject) begin
      err_code <= reject_code;
    end
    if (load_word) begin
      word <= (valid[addr] ? rdata : '0) | ((addr == LAST_WORD) ? PAD_MASK : '0);
    end else if (alloc) begin
      word[low_bit] <= 1'b1;
    end
    if (alloc) begin
      pend <= found_sec;
    end
    if (emit) begin
      sector_number <= emit_sec;
      next_sector   <= emit_next;
      last_of_run   <= emit_last;
      status        <= emit_status;
    end
  end

  assign empty = !out_valid;

endmodule

### rtl/bitmap_sector_chain_allocator.sv
// Top level of the bitmap sector chain allocator.
// Depends on bsca_pkg, bsca_front, bsca_back (and bsca_ram through it).
//
// Usage: push a request_size while full is low. Each request yields its
// results on the output queue: one per allocated sector, in ascending
// order, each naming its sector (base_sector + map index), the next
// sector of the chain and a last flag; or a single error result (status 1
// for too little free space, 2 for a size of zero or above the run limit).
// Results are taken with pop while empty is low.
// base_sector is to be written by cfg_write/base_sector only while the block is idle; the block does not enforce this.
// An error result passes through B_ERR and the output register after the
// request is taken. An allocation starts in B_IDLE, visits each map word
// in turn (RAM read, word load, write back), marks each sector found in
// B_SCAN, then emits the final result from B_FLUSH. One request is worked
// at a time; up to two more wait in the front queue. The scan sets the
// throughput.
// Reset: the map is all free, the free count is the full sector count
// and base_sector is 73; no RAM clearing pass is needed.
// Stall: when pop stays low the scan holds at the next result.
module bitmap_sector_chain_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [bsca_pkg::SIZE_W-1:0]   request_size,
  input  logic                          cfg_write,
  input  logic [bsca_pkg::BASE_W-1:0]   base_sector,
  output logic                          empty,
  input  logic                          pop,
  output logic [bsca_pkg::SECTOR_W-1:0] sector_number,
  output logic [bsca_pkg::SECTOR_W-1:0] next_sector,
  output logic                          last_of_run,
  output logic [bsca_pkg::STATUS_W-1:0] status
);
  import bsca_pkg::*;

  logic q_valid;
  logic q_take;
  req_t q_req;

  bsca_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .request_size (request_size),
    .q_valid      (q_valid),
    .q_take       (q_take),
    .q_req        (q_req)
  );

  bsca_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .base_sector   (base_sector),
    .q_valid       (q_valid),
    .q_take        (q_take),
    .q_req         (q_req),
    .empty         (empty),
    .pop           (pop),
    .sector_number (sector_number),
    .next_sector   (next_sector),
    .last_of_run   (last_of_run),
    .status        (status)
  );

endmodule

### rtl/bsca_checker.sv
// Port-level checks for the bitmap sector chain allocator, bound to the
// top level. Depends on bsca_pkg.
module bsca_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [bsca_pkg::SECTOR_W-1:0] sector_number,
  input  logic [bsca_pkg::SECTOR_W-1:0] next_sector,
  input  logic                          last_of_run,
  input  logic [bsca_pkg::STATUS_W-1:0] status
);
  import bsca_pkg::*;

  // error results carry no sectors and close their request
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |->
      (last_of_run && sector_number == '0 && next_sector == '0))
    else $error("error result with sector data or without last flag");

  // only successful chains continue
  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last_of_run) |-> (status == ST_OK))
    else $error("non-final result with error status");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=>
      (!empty && $stable(sector_number) && $stable(next_sector) &&
       $stable(last_of_run) && $stable(status)))
    else $error("waiting result changed or vanished");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

endmodule

bind bitmap_sector_chain_allocator bsca_checker u_bsca_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .sector_number (sector_number),
  .next_sector   (next_sector),
  .last_of_run   (last_of_run),
  .status        (status)
);
